// File: design/postfix_stack_evaluator_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the postfix stack evaluator.
// Clocked, reset-qualified forms for same-cycle and next-cycle implications.
// ----------------------------------------------------------------------------
`ifndef POSTFIX_STACK_EVALUATOR_CORE_ASSERT_SVH
`define POSTFIX_STACK_EVALUATOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("postfix evaluator check failed");

// The consequent must hold in the cycle after the antecedent.
`define PSE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("postfix evaluator check failed");

`endif

// File: design/pse_pkg.sv
// ----------------------------------------------------------------------------
// pse_pkg
// Shared constants, codes and types of the postfix stack evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package pse_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int DATA_W      = 64;
	localparam int HALF_W      = DATA_W / 2;
	localparam int FUNC_W      = 5;
	localparam int STATUS_W    = 3;
	localparam int SP_W        = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int SHIFT_W     = $clog2(DATA_W);
	localparam int DIV_CNT_W   = $clog2(DATA_W);

	localparam logic [FUNC_W-1:0] FN_PUSH  = 5'd0;
	localparam logic [FUNC_W-1:0] FN_NOT   = 5'd1;
	localparam logic [FUNC_W-1:0] FN_COMPL = 5'd2;
	localparam logic [FUNC_W-1:0] FN_MUL   = 5'd3;
	localparam logic [FUNC_W-1:0] FN_DIV   = 5'd4;
	localparam logic [FUNC_W-1:0] FN_MOD   = 5'd5;
	localparam logic [FUNC_W-1:0] FN_ADD   = 5'd6;
	localparam logic [FUNC_W-1:0] FN_SUB   = 5'd7;
	localparam logic [FUNC_W-1:0] FN_LSH   = 5'd8;
	localparam logic [FUNC_W-1:0] FN_RSH   = 5'd9;
	localparam logic [FUNC_W-1:0] FN_GT    = 5'd10;
	localparam logic [FUNC_W-1:0] FN_LT    = 5'd11;
	localparam logic [FUNC_W-1:0] FN_GE    = 5'd12;
	localparam logic [FUNC_W-1:0] FN_LE    = 5'd13;
	localparam logic [FUNC_W-1:0] FN_EQ    = 5'd14;
	localparam logic [FUNC_W-1:0] FN_NE    = 5'd15;
	localparam logic [FUNC_W-1:0] FN_AND   = 5'd16;
	localparam logic [FUNC_W-1:0] FN_OR    = 5'd17;
	localparam logic [FUNC_W-1:0] FN_XOR   = 5'd18;

	localparam logic [STATUS_W-1:0] STS_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] STS_UNDERFLOW = 3'd1;
	localparam logic [STATUS_W-1:0] STS_OVERFLOW  = 3'd2;
	localparam logic [STATUS_W-1:0] STS_DIV_ZERO  = 3'd3;
	localparam logic [STATUS_W-1:0] STS_BAD_SHIFT = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_MUL,
		ST_DIV,
		ST_FINISH
	} pse_state_t;

	typedef struct packed {
		logic              start;
		logic [DATA_W-1:0] num;
		logic [DATA_W-1:0] den;
	} pse_div_req_t;

	typedef struct packed {
		logic              done;
		logic [DATA_W-1:0] quo;
		logic [DATA_W-1:0] rem;
	} pse_div_rsp_t;

endpackage

`default_nettype wire

// File: design/pse_if.sv
// ----------------------------------------------------------------------------
// pse_if
// Token and result channels of the postfix stack evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

interface pse_tok_if import pse_pkg::*;;
	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [DATA_W-1:0] value;
	logic              last;

	modport source (output valid, output func, output value, output last, input ready);
	modport sink (input valid, input func, input value, input last, output ready);
endinterface

interface pse_res_if import pse_pkg::*;;
	logic                valid;
	logic                ready;
	logic [DATA_W-1:0]   result;
	logic [STATUS_W-1:0] status;

	modport source (output valid, output result, output status, input ready);
	modport sink (input valid, input result, input status, output ready);
endinterface

`default_nettype wire

// File: design/postfix_stack_evaluator_core.sv
// ----------------------------------------------------------------------------
// postfix_stack_evaluator_core
// Evaluates postfix expressions of 64-bit signed tokens on a bounded stack.
// The top of the stack is held in a register and the entries beneath it in a
// synchronous RAM, so a token takes one word at a time. A push, a unary
// operator, an unused code, a binary operator that fails its checks or any
// word after an error is done as it is accepted. An add, shift, compare or
// logic operator goes through the execute state for the RAM read of the
// second operand, a multiply then through one shared 32 by 32 multiplier,
// and a divide or modulo then through the bit-serial divider. A word marked
// last then goes through the finish state to load the result register and
// waits there while that register still holds an unaccepted result; once
// loaded, the register holds the result while the next one is being accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module postfix_stack_evaluator_core import pse_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	pse_tok_if.sink   tok,
	pse_res_if.source res
);

	pse_state_t          state_q, state_d;
	logic [SP_W-1:0]     sp_q, sp_d;
	logic [STATUS_W-1:0] err_q, err_d;
	logic [DATA_W-1:0]   tos_q, tos_d;
	logic [FUNC_W-1:0]   func_q;
	logic                last_q;
	logic [1:0]          mstep_q, mstep_d;
	logic [DATA_W-1:0]   mlo_q;
	logic [HALF_W-1:0]   cross_q;
	logic                out_valid_q;
	logic [DATA_W-1:0]   out_result_q;
	logic [STATUS_W-1:0] out_status_q;

	logic                accept;
	logic                out_load;
	logic [DATA_W-1:0]   out_result_d;
	logic [STATUS_W-1:0] out_status_d;
	logic                ram_we;
	logic                ram_re;
	logic [SP_W-1:0]     sp_m1;
	logic [SP_W-1:0]     sp_m2;
	logic [DATA_W-1:0]   opa;
	logic [DATA_W-1:0]   alu;
	logic                lt_ab;
	logic                lt_ba;
	logic [HALF_W-1:0]   mul_x;
	logic [HALF_W-1:0]   mul_y;
	logic [DATA_W-1:0]   prod;
	logic [DATA_W-1:0]   div_val;
	pse_div_req_t        div_req;
	pse_div_rsp_t        div_rsp;

	function automatic logic [DATA_W-1:0] magnitude(input logic [DATA_W-1:0] v);
		magnitude = v[DATA_W-1] ? (~v + 1'b1) : v;
	endfunction

	assign sp_m1  = sp_q - SP_W'(1);
	assign sp_m2  = sp_q - SP_W'(2);
	assign accept = tok.valid && tok.ready;

	pse_ram #(
		.WIDTH(DATA_W),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (ram_we),
		.waddr(sp_m1[ADDR_W-1:0]),
		.wdata(tos_q),
		.re   (ram_re),
		.raddr(sp_m2[ADDR_W-1:0]),
		.rdata(opa)
	);

	pse_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	always_comb begin
		lt_ab = ($signed(opa) < $signed(tos_q));
		lt_ba = ($signed(tos_q) < $signed(opa));
		case (func_q)
			FN_ADD:  alu = opa + tos_q;
			FN_SUB:  alu = opa - tos_q;
			FN_LSH:  alu = opa << tos_q[SHIFT_W-1:0];
			FN_RSH:  alu = $signed(opa) >>> tos_q[SHIFT_W-1:0];
			FN_GT:   alu = {{(DATA_W-1){1'b0}}, lt_ba};
			FN_LT:   alu = {{(DATA_W-1){1'b0}}, lt_ab};
			FN_GE:   alu = {{(DATA_W-1){1'b0}}, !lt_ab};
			FN_LE:   alu = {{(DATA_W-1){1'b0}}, !lt_ba};
			FN_EQ:   alu = {{(DATA_W-1){1'b0}}, opa == tos_q};
			FN_NE:   alu = {{(DATA_W-1){1'b0}}, opa != tos_q};
			FN_AND:  alu = opa & tos_q;
			FN_OR:   alu = opa | tos_q;
			default: alu = opa ^ tos_q;
		endcase
	end

	always_comb begin
		case (mstep_q)
			2'd0: begin
				mul_x = opa[HALF_W-1:0];
				mul_y = tos_q[HALF_W-1:0];
			end
			2'd1: begin
				mul_x = opa[HALF_W-1:0];
				mul_y = tos_q[DATA_W-1:HALF_W];
			end
			default: begin
				mul_x = opa[DATA_W-1:HALF_W];
				mul_y = tos_q[HALF_W-1:0];
			end
		endcase
		prod = mul_x * mul_y;
	end

	always_comb begin
		if (func_q == FN_DIV) begin
			div_val = (opa[DATA_W-1] ^ tos_q[DATA_W-1]) ? (~div_rsp.quo + 1'b1) : div_rsp.quo;
		end else begin
			div_val = opa[DATA_W-1] ? (~div_rsp.rem + 1'b1) : div_rsp.rem;
		end
	end

	always_comb begin
		state_d       = state_q;
		sp_d          = sp_q;
		err_d         = err_q;
		tos_d         = tos_q;
		mstep_d       = mstep_q;
		ram_we        = 1'b0;
		ram_re        = 1'b0;
		out_load      = 1'b0;
		out_result_d  = '0;
		out_status_d  = STS_OK;
		div_req.start = 1'b0;
		div_req.num   = magnitude(opa);
		div_req.den   = magnitude(tos_q);
		tok.ready     = (state_q == ST_IDLE);

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = tok.last ? ST_FINISH : ST_IDLE;
					if (err_q == STS_OK) begin
						if (tok.func == FN_PUSH) begin
							if (sp_q == SP_W'(STACK_DEPTH)) begin
								err_d = STS_OVERFLOW;
							end else begin
								ram_we = (sp_q != '0);
								tos_d  = tok.value;
								sp_d   = sp_q + 1'b1;
							end
						end else if (tok.func == FN_NOT || tok.func == FN_COMPL) begin
							if (sp_q == '0) begin
								err_d = STS_UNDERFLOW;
							end else if (tok.func == FN_NOT) begin
								tos_d = {{(DATA_W-1){1'b0}}, tos_q == '0};
							end else begin
								tos_d = ~tos_q;
							end
						end else if (tok.func >= FN_MUL && tok.func <= FN_XOR) begin
							if (sp_q < SP_W'(2)) begin
								err_d = STS_UNDERFLOW;
							end else if ((tok.func == FN_DIV || tok.func == FN_MOD)
									&& tos_q == '0) begin
								err_d = STS_DIV_ZERO;
							end else if ((tok.func == FN_LSH || tok.func == FN_RSH)
									&& (|tos_q[DATA_W-1:SHIFT_W])) begin
								err_d = STS_BAD_SHIFT;
							end else begin
								ram_re  = 1'b1;
								state_d = ST_EXEC;
							end
						end
					end
				end
			end
			ST_EXEC: begin
				if (func_q == FN_MUL) begin
					mstep_d = 2'd0;
					state_d = ST_MUL;
				end else if (func_q == FN_DIV || func_q == FN_MOD) begin
					div_req.start = 1'b1;
					state_d       = ST_DIV;
				end else begin
					tos_d   = alu;
					sp_d    = sp_m1;
					state_d = last_q ? ST_FINISH : ST_IDLE;
				end
			end
			ST_MUL: begin
				mstep_d = mstep_q + 1'b1;
				if (mstep_q == 2'd2) begin
					tos_d   = mlo_q + {cross_q + prod[HALF_W-1:0], {HALF_W{1'b0}}};
					sp_d    = sp_m1;
					state_d = last_q ? ST_FINISH : ST_IDLE;
				end
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					tos_d   = div_val;
					sp_d    = sp_m1;
					state_d = last_q ? ST_FINISH : ST_IDLE;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || res.ready) begin
					out_load = 1'b1;
					if (err_q != STS_OK) begin
						out_status_d = err_q;
					end else if (sp_q == '0) begin
						out_status_d = STS_UNDERFLOW;
					end else begin
						out_result_d = tos_q;
					end
					sp_d    = '0;
					err_d   = STS_OK;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sp_q        <= '0;
			err_q       <= STS_OK;
			mstep_q     <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			sp_q    <= sp_d;
			err_q   <= err_d;
			mstep_q <= mstep_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		tos_q <= tos_d;
		if (accept) begin
			func_q <= tok.func;
			last_q <= tok.last;
		end
		if (state_q == ST_MUL && mstep_q == 2'd0) begin
			mlo_q <= prod;
		end
		if (state_q == ST_MUL && mstep_q == 2'd1) begin
			cross_q <= prod[HALF_W-1:0];
		end
		if (out_load) begin
			out_result_q <= out_result_d;
			out_status_q <= out_status_d;
		end
	end

	assign res.valid  = out_valid_q;
	assign res.result = out_result_q;
	assign res.status = out_status_q;

endmodule

`default_nettype wire

// File: design/pse_ram.sv
// ----------------------------------------------------------------------------
// pse_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module pse_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: design/pse_div.sv
// ----------------------------------------------------------------------------
// pse_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pse_div import pse_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  pse_div_req_t req,
	output pse_div_rsp_t rsp
);

	localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DATA_W - 1);

	logic [DATA_W-1:0]    rem_q;
	logic [DATA_W-1:0]    quo_q;
	logic [DATA_W-1:0]    den_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DATA_W-1:0]    shifted;
	logic                 fits;

	always_comb begin
		shifted = {rem_q[DATA_W-2:0], quo_q[DATA_W-1]};
		fits    = (shifted >= den_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= fits ? (shifted - den_q) : shifted;
			quo_q <= {quo_q[DATA_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q;

endmodule

`default_nettype wire

// File: design/pse_checker.sv
// ----------------------------------------------------------------------------
// pse_checker
// Port-level checks on the postfix stack evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "postfix_stack_evaluator_core_assert.svh"

module pse_checker import pse_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                tok_valid,
	input logic                tok_ready,
	input logic                tok_last,
	input logic                res_valid,
	input logic                res_ready,
	input logic [DATA_W-1:0]   res_result,
	input logic [STATUS_W-1:0] res_status
);

	`PSE_ASSERT_IMP(a_error_result_zero, clk, arst_n, res_valid && res_status != STS_OK, res_result == '0)
	`PSE_ASSERT_IMP(a_status_known, clk, arst_n, res_valid, res_status <= STS_BAD_SHIFT)
	`PSE_ASSERT_NXT(a_last_busy, clk, arst_n, tok_valid && tok_ready && tok_last, !tok_ready)
	`PSE_ASSERT_NXT(a_result_held, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res_result) && $stable(res_status))

endmodule

bind postfix_stack_evaluator_core pse_checker u_pse_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.tok_valid (tok.valid),
	.tok_ready (tok.ready),
	.tok_last  (tok.last),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_result(res.result),
	.res_status(res.status)
);

`default_nettype wire

// File: test/postfix_stack_evaluator_core_tb.sv
// ----------------------------------------------------------------------------
// postfix_stack_evaluator_core_tb
// Drives postfix token words into the evaluator and checks every result word
// against an in-bench stack predictor. Directed expressions cover the error
// and wrap cases, then random expressions run with random idling on both
// channels and one long hold-off on the result side.
// ----------------------------------------------------------------------------
module postfix_stack_evaluator_core_tb import pse_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [FUNC_W-1:0] FN_UNUSED = '1;
	localparam logic [DATA_W-1:0] VAL_MIN   = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic [DATA_W-1:0] VAL_MAX   = {1'b0, {(DATA_W-1){1'b1}}};
	localparam int TOKEN_TARGET = 1000;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 100;

	typedef struct {
		logic [DATA_W-1:0]   result;
		logic [STATUS_W-1:0] status;
	} expr_result_t;

	class expr_scoreboard;
		logic [DATA_W-1:0]   operands[STACK_DEPTH];
		int unsigned         depth;
		logic [STATUS_W-1:0] sticky_err;
		expr_result_t        pending_results[$];
		int                  errors;
		int                  results_seen;

		function new();
			depth = 0;
			sticky_err = STS_OK;
			errors = 0;
			results_seen = 0;
		endfunction

		function logic [STATUS_W-1:0] apply_binary(input logic [FUNC_W-1:0] f,
				input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b,
				output logic [DATA_W-1:0] r);
			logic [DATA_W-1:0] ma;
			logic [DATA_W-1:0] mb;
			r = '0;
			case (f)
				FN_MUL: r = a * b;
				FN_DIV, FN_MOD: begin
					if (b == '0)
						return STS_DIV_ZERO;
					ma = a[DATA_W-1] ? -a : a;
					mb = b[DATA_W-1] ? -b : b;
					if (f == FN_DIV)
						r = (a[DATA_W-1] ^ b[DATA_W-1]) ? -(ma / mb) : ma / mb;
					else
						r = a[DATA_W-1] ? -(ma % mb) : ma % mb;
				end
				FN_ADD: r = a + b;
				FN_SUB: r = a - b;
				FN_LSH, FN_RSH: begin
					if (b > DATA_W - 1)
						return STS_BAD_SHIFT;
					if (f == FN_LSH)
						r = a << b[SHIFT_W-1:0];
					else
						r = $signed(a) >>> b[SHIFT_W-1:0];
				end
				FN_GT: r = DATA_W'($signed(a) > $signed(b));
				FN_LT: r = DATA_W'($signed(a) < $signed(b));
				FN_GE: r = DATA_W'($signed(a) >= $signed(b));
				FN_LE: r = DATA_W'($signed(a) <= $signed(b));
				FN_EQ: r = DATA_W'(a == b);
				FN_NE: r = DATA_W'(a != b);
				FN_AND: r = a & b;
				FN_OR: r = a | b;
				default: r = a ^ b;
			endcase
			return STS_OK;
		endfunction

		function void note_token(input logic [FUNC_W-1:0] f, input logic [DATA_W-1:0] v,
				input logic l);
			logic [DATA_W-1:0]   r;
			logic [STATUS_W-1:0] code;
			expr_result_t        outcome;
			if (sticky_err == STS_OK) begin
				if (f == FN_PUSH) begin
					if (depth >= STACK_DEPTH) begin
						sticky_err = STS_OVERFLOW;
					end else begin
						operands[depth] = v;
						depth++;
					end
				end else if (f == FN_NOT || f == FN_COMPL) begin
					if (depth < 1)
						sticky_err = STS_UNDERFLOW;
					else if (f == FN_NOT)
						operands[depth-1] = DATA_W'(operands[depth-1] == '0);
					else
						operands[depth-1] = ~operands[depth-1];
				end else if (f <= FN_XOR) begin
					if (depth < 2) begin
						sticky_err = STS_UNDERFLOW;
					end else begin
						code = apply_binary(f, operands[depth-2], operands[depth-1], r);
						if (code != STS_OK) begin
							sticky_err = code;
						end else begin
							depth--;
							operands[depth-1] = r;
						end
					end
				end
			end
			if (l) begin
				if (sticky_err == STS_OK && depth == 0)
					sticky_err = STS_UNDERFLOW;
				if (sticky_err == STS_OK)
					outcome.result = operands[depth-1];
				else
					outcome.result = '0;
				outcome.status = sticky_err;
				pending_results.insert(pending_results.size(), outcome);
				depth = 0;
				sticky_err = STS_OK;
			end
		endfunction

		task report(input string what);
			$display("%0t ns: mismatch: %s", $time, what);
			errors++;
		endtask

		task check_result(input logic [DATA_W-1:0] r, input logic [STATUS_W-1:0] s);
			expr_result_t want;
			results_seen++;
			if (pending_results.size() == 0) begin
				report($sformatf("unexpected result %h status %0d", r, s));
			end else begin
				want = pending_results.pop_front();
				if (r !== want.result)
					report($sformatf("result %h, expected %h", r, want.result));
				if (s !== want.status)
					report($sformatf("status %0d, expected %0d", s, want.status));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	bit   calm;
	int   tokens_sent;
	int   hold_left;
	bit   held;

	expr_scoreboard sb = new();

	pse_tok_if tok_ch();
	pse_res_if res_ch();

	postfix_stack_evaluator_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.tok    (tok_ch),
		.res    (res_ch)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic logic [DATA_W-1:0] pick_value();
		logic [DATA_W-1:0] v;
		case ($urandom_range(5))
			0: begin
				v = DATA_W'($urandom_range(16));
				v = v - DATA_W'(8);
			end
			1: begin
				case ($urandom_range(3))
					0: v = VAL_MIN;
					1: v = VAL_MAX;
					2: v = '0;
					default: v = '1;
				endcase
			end
			default: v = {$urandom, $urandom};
		endcase
		return v;
	endfunction

	task automatic send_token(input logic [FUNC_W-1:0] f, input logic [DATA_W-1:0] v,
			input logic l);
		while (!calm && $urandom_range(99) < 29) begin
			tok_ch.valid <= 1'b0;
			@(negedge clk);
		end
		tok_ch.valid <= 1'b1;
		tok_ch.func  <= f;
		tok_ch.value <= v;
		tok_ch.last  <= l;
		do
			@(posedge clk);
		while (!tok_ch.ready);
		sb.note_token(f, v, l);
		tokens_sent++;
		@(negedge clk);
	endtask

	task automatic send_expression();
		int                n;
		int                depth;
		int                pick;
		logic              l;
		logic [FUNC_W-1:0] op;
		logic [DATA_W-1:0] arg;
		pick = $urandom_range(99);
		depth = 0;
		if (pick < 75) begin
			n = $urandom_range(1, 12);
			for (int i = 0; i < n; i++) begin
				l = (i == n - 1);
				pick = $urandom_range(99);
				if (depth < 1 || (pick < 40 && depth < STACK_DEPTH)) begin
					send_token(FN_PUSH, pick_value(), l);
					depth++;
				end else if (pick < 50 || depth < 2) begin
					send_token($urandom_range(1) ? FN_NOT : FN_COMPL, pick_value(), l);
				end else begin
					op = FUNC_W'($urandom_range(FN_MUL, FN_XOR));
					if ((op == FN_DIV || op == FN_MOD || op == FN_LSH || op == FN_RSH)
							&& depth < STACK_DEPTH && $urandom_range(99) < 80) begin
						if (op == FN_LSH || op == FN_RSH) begin
							arg = DATA_W'($urandom_range(DATA_W - 1));
						end else begin
							arg = pick_value();
							if (arg == '0)
								arg = DATA_W'(3);
						end
						send_token(FN_PUSH, arg, 1'b0);
						depth++;
					end
					send_token(op, pick_value(), l);
					depth--;
				end
			end
		end else if (pick < 90) begin
			n = $urandom_range(1, 10);
			for (int i = 0; i < n; i++)
				send_token(FUNC_W'($urandom_range(FN_UNUSED)), pick_value(),
					(i == n - 1) || ($urandom_range(7) == 0));
		end else begin
			n = $urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 2);
			for (int i = 0; i < n; i++)
				send_token(FN_PUSH, pick_value(), 1'b0);
			n = $urandom_range(1, 4);
			for (int i = 0; i < n; i++)
				send_token(FUNC_W'($urandom_range(FN_MUL, FN_XOR)), pick_value(),
					i == n - 1);
		end
	endtask

	initial begin
		res_ch.ready <= 1'b0;
		hold_left = 0;
		held = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && sb.results_seen >= 20) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				res_ch.ready <= 1'b0;
				hold_left--;
			end else if (!calm && $urandom_range(99) < 29) begin
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready)
			sb.check_result(res_ch.result, res_ch.status);
	end

	initial begin
		logic [DATA_W-1:0] corner_vals[4];
		int                exprs;
		int                waited;
		corner_vals[0] = VAL_MAX;
		corner_vals[1] = VAL_MIN;
		corner_vals[2] = '0;
		corner_vals[3] = '1;
		calm = 1'b0;
		tokens_sent = 0;
		arst_n <= 1'b0;
		tok_ch.valid <= 1'b0;
		tok_ch.func  <= FN_PUSH;
		tok_ch.value <= '0;
		tok_ch.last  <= 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// The most negative value divided by minus one wraps; its remainder is zero.
		send_token(FN_PUSH, VAL_MIN, 1'b0);
		send_token(FN_PUSH, '1, 1'b0);
		send_token(FN_DIV, '0, 1'b1);
		send_token(FN_PUSH, VAL_MIN, 1'b0);
		send_token(FN_PUSH, '1, 1'b0);
		send_token(FN_MOD, '0, 1'b1);
		send_token(FN_PUSH, DATA_W'(5), 1'b0);
		send_token(FN_PUSH, '0, 1'b0);
		send_token(FN_DIV, '0, 1'b0);
		send_token(FN_XOR, '0, 1'b1);
		send_token(FN_PUSH, DATA_W'(1), 1'b0);
		send_token(FN_PUSH, DATA_W'(DATA_W), 1'b0);
		send_token(FN_LSH, '0, 1'b1);
		send_token(FN_UNUSED, VAL_MAX, 1'b1);
		send_token(FN_NOT, '0, 1'b1);
		for (int i = 0; i <= STACK_DEPTH; i++)
			send_token(FN_PUSH, corner_vals[i % 4], i == STACK_DEPTH);
		send_token(FN_PUSH, VAL_MAX, 1'b0);
		send_token(FN_PUSH, DATA_W'(3), 1'b1);

		exprs = 0;
		while (tokens_sent < TOKEN_TARGET) begin
			calm = (exprs >= 40 && exprs < 60);
			send_expression();
			exprs++;
		end
		calm = 1'b0;
		tok_ch.valid <= 1'b0;

		waited = 0;
		while (sb.pending_results.size() != 0) begin
			@(posedge clk);
			waited++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
